// ===== hw/rtl/lbd_pkg.sv =====
`timescale 1ns / 1ps

package lbd_pkg;

  localparam int HistDepth = 200;
  localparam int IdxW      = $clog2(HistDepth);
  localparam int CntW      = $clog2(HistDepth + 1);
  localparam int SumW      = CntW + 1;
  localparam int AccW      = $clog2(2 * HistDepth + 1);
  localparam int LvlW      = 17;
  localparam int GapW      = 8;
  localparam int SensW     = 4;
  localparam int EntW      = LvlW + 1;
  localparam int TotW      = EntW + IdxW;
  localparam int ProdW     = TotW + CntW + 1;
  localparam int DivCntW   = $clog2(ProdW + 1);
  localparam int CfgIdxW   = 3;

  // divide by HistDepth as a multiply by a rounded-up reciprocal;
  // |sum * period| < HistDepth * 2^LvlW, and the result is exact over that range
  localparam int MagW      = LvlW + IdxW;
  localparam int RecipSh   = MagW + IdxW;
  localparam int RecipW    = MagW + 2;
  localparam int DvPW      = MagW + RecipW;
  localparam logic [RecipW-1:0] RecipMul =
    RecipW'(((64'd1 << RecipSh) + 64'(HistDepth) - 64'd1) / 64'(HistDepth));

  typedef enum logic [CfgIdxW-1:0] {
    RegSilence   = 3'd0,
    RegThickFlr  = 3'd1,
    RegQuietEnt  = 3'd2,
    RegQuietExt  = 3'd3,
    RegMinGap    = 3'd4,
    RegBaseSens  = 3'd5
  } cfg_reg_e;

endpackage

// ===== hw/rtl/lbd_ram.sv =====
`timescale 1ns / 1ps

module lbd_ram #(
  parameter int Width = 18,
  parameter int Depth = 200
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/loudness_beat_detector_unit.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+---------------------------------
// in       | in        | in_valid_i / in_stall_o | loudness_i
// out      | out       | out_valid_o/out_stall_i | beat_o, thickness_o, quiet_start_o
// cfg      | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Steps: a request with no beat candidate runs update then done; a candidate
//   adds history reads (one RAM read port, one read then one accumulate per
//   entry), a multiply, a reciprocal divide and a compare.
// Reset clears level, counters, quiet flag, history valid bits; no clearing pass.
// History clear on silence/overrun drops all valid bits together in the update state.
// A finished result waits in the output register; the next request is taken
// meanwhile and only its final hand-off waits on out_stall_i.

module loudness_beat_detector_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [lbd_pkg::LvlW-1:0]   loudness_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       beat_o,
  output logic [1:0]                 thickness_o,
  output logic                       quiet_start_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [lbd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lbd_pkg::LvlW-1:0]   cfg_data_i
);

  localparam int D = lbd_pkg::HistDepth;

  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StUpd  = 7'b0000010,
    StRd   = 7'b0000100,
    StAcc  = 7'b0001000,
    StMul  = 7'b0010000,
    StDiv  = 7'b0100000,
    StDone = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // config
  logic [lbd_pkg::LvlW-1:0]  silence_q, thick_flr_q, q_enter_q, q_exit_q;
  logic [lbd_pkg::GapW-1:0]  min_gap_q;
  logic [lbd_pkg::SensW-1:0] base_sens_q;

  // block state
  logic [lbd_pkg::LvlW-1:0] lvl_q, lvl_d;
  logic [lbd_pkg::CntW-1:0] fsb_q, fsb_d;
  logic [lbd_pkg::CntW-1:0] prev_q, prev_d;
  logic [lbd_pkg::IdxW-1:0] rb_q, rb_d;
  logic                     quiet_q, quiet_d;
  logic [D-1:0]             hv_q, hv_d;

  // per-request work registers
  logic [lbd_pkg::LvlW-1:0]   loud_q;
  logic [lbd_pkg::IdxW-1:0]   ptr_q, ptr_d;
  logic [lbd_pkg::AccW-1:0]   acc_q, acc_d;
  logic signed [lbd_pkg::TotW-1:0] tot_q, tot_d;
  logic                       rdv_q, rdv_d;
  logic [lbd_pkg::ProdW-1:0]  dq_q, dq_d;
  logic                       neg_q, neg_d;
  logic [lbd_pkg::DivCntW-1:0] dcnt_q, dcnt_d;
  logic                       pb_q, pb_d;
  logic [1:0]                 pt_q, pt_d;
  logic                       pq_q, pq_d;

  logic       ov_q, ov_d;
  logic       ob_q, ob_d;
  logic [1:0] ot_q, ot_d;
  logic       oq_q, oq_d;

  // RAM
  logic                          ram_we;
  logic [lbd_pkg::IdxW-1:0]      ram_waddr, ram_raddr;
  logic [lbd_pkg::EntW-1:0]      ram_wdata, ram_rdata;

  lbd_ram #(
    .Width(lbd_pkg::EntW),
    .Depth(D)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // update-stage arithmetic
  logic [lbd_pkg::LvlW+2:0] lvl_sum;
  logic [lbd_pkg::LvlW-1:0] new_lvl;
  logic [lbd_pkg::CntW:0]   fsb_inc;
  logic                     clr;
  logic [lbd_pkg::CntW-1:0] fsb_new;
  logic [lbd_pkg::SumW-1:0] pos_sum;
  logic [lbd_pkg::IdxW-1:0] pos;
  logic                     cand;
  logic [lbd_pkg::LvlW+2:0] loud4, lvl5;
  logic [lbd_pkg::LvlW+1:0] loud2, lvl1, lvl2, lvl3;
  logic [1:0]               thick;
  logic [lbd_pkg::LvlW-1:0] q_thr;
  logic [lbd_pkg::AccW-1:0] per_acc;

  always_comb begin
    lvl_sum = ({3'b0, lvl_q} << 3) - {3'b0, lvl_q} + {3'b0, loud_q};
    new_lvl = lvl_sum[lbd_pkg::LvlW+2:3];
    fsb_inc = {1'b0, fsb_q} + 1'b1;
    clr     = (new_lvl < silence_q) || (fsb_inc > (lbd_pkg::CntW+1)'(D));
    fsb_new = clr ? '0 : fsb_inc[lbd_pkg::CntW-1:0];
    pos_sum = lbd_pkg::SumW'(rb_q) + lbd_pkg::SumW'(fsb_new);
    pos     = (pos_sum >= lbd_pkg::SumW'(D)) ? lbd_pkg::IdxW'(pos_sum - lbd_pkg::SumW'(D))
                                             : lbd_pkg::IdxW'(pos_sum);
    loud4   = {1'b0, loud_q, 2'b00};
    lvl5    = ({3'b0, new_lvl} << 2) + {3'b0, new_lvl};
    cand    = (lbd_pkg::SumW'(fsb_new) > lbd_pkg::SumW'(min_gap_q)) && (fsb_new != '0) &&
              (new_lvl > silence_q) && (loud4 > lvl5);
    loud2   = {1'b0, loud_q, 1'b0};
    lvl1    = {2'b0, new_lvl};
    lvl2    = {1'b0, new_lvl, 1'b0};
    lvl3    = lvl2 + lvl1;
    // min(3, 2L/S) by compares, 0 below the thickness floor; S == 0 saturates only with a zero floor
    priority if (new_lvl < thick_flr_q) thick = 2'd0;
    else if (loud2 >= lvl3)             thick = 2'd3;
    else if (loud2 >= lvl2)             thick = 2'd2;
    else if (loud2 >= lvl1)             thick = 2'd1;
    else                                thick = 2'd0;
    q_thr   = quiet_q ? q_exit_q : q_enter_q;
    per_acc = lbd_pkg::AccW'(fsb_new) << 1;
  end

  // loop / divide / compare arithmetic
  logic [lbd_pkg::SumW-1:0]        ptr_nx;
  logic [lbd_pkg::AccW-1:0]        acc_nx;
  logic signed [lbd_pkg::TotW-1:0] ent_ext;
  logic signed [lbd_pkg::ProdW-1:0] prod;
  logic [lbd_pkg::DvPW-1:0]        dv_p;
  logic signed [lbd_pkg::ProdW-1:0] quo;
  logic [lbd_pkg::CntW-1:0]        pdiff;
  logic [lbd_pkg::SensW:0]         sens;
  logic signed [lbd_pkg::ProdW+lbd_pkg::SensW+1:0] score;

  always_comb begin
    ptr_nx  = (ptr_q >= fsb_q) ? lbd_pkg::SumW'(ptr_q) - lbd_pkg::SumW'(fsb_q)
                               : lbd_pkg::SumW'(ptr_q) + lbd_pkg::SumW'(D) -
                                 lbd_pkg::SumW'(fsb_q);
    acc_nx  = acc_q + lbd_pkg::AccW'(fsb_q);
    ent_ext = rdv_q ? lbd_pkg::TotW'(signed'(ram_rdata)) : '0;
    prod    = lbd_pkg::ProdW'(tot_q) * signed'({1'b0, fsb_q});
    // magnitude / HistDepth by reciprocal multiply
    dv_p    = lbd_pkg::DvPW'(dq_q[lbd_pkg::MagW-1:0]) * lbd_pkg::DvPW'(lbd_pkg::RecipMul);
    quo     = neg_q ? -signed'(dq_q) : signed'(dq_q);
    pdiff   = (fsb_q > prev_q) ? fsb_q - prev_q : prev_q - fsb_q;
    sens    = {1'b0, base_sens_q} +
              ((pdiff < lbd_pkg::CntW'(6)) ? (lbd_pkg::SensW+1)'(2'd3 - 2'(pdiff >> 1)) : '0);
    score   = (lbd_pkg::ProdW+lbd_pkg::SensW+2)'(quo) * signed'({1'b0, sens});
  end

  always_comb begin
    state_d = state_q;
    lvl_d = lvl_q;  fsb_d = fsb_q;  prev_d = prev_q;  rb_d = rb_q;
    quiet_d = quiet_q;  hv_d = hv_q;
    ptr_d = ptr_q;  acc_d = acc_q;  tot_d = tot_q;  rdv_d = rdv_q;
    dq_d = dq_q;  neg_d = neg_q;  dcnt_d = dcnt_q;
    pb_d = pb_q;  pt_d = pt_q;  pq_d = pq_q;
    ov_d = ov_q & out_stall_i;
    ob_d = ob_q;  ot_d = ot_q;  oq_d = oq_q;
    ram_we = 1'b0;  ram_waddr = pos;
    ram_wdata = {1'b0, loud_q} - {1'b0, new_lvl};
    ram_raddr = ptr_q;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StUpd;
      end
      StUpd: begin
        lvl_d  = new_lvl;
        fsb_d  = fsb_new;
        ram_we = 1'b1;
        hv_d   = (clr ? '0 : hv_q) | (D'(1) << pos);
        pt_d   = thick;
        pb_d   = 1'b0;
        if (new_lvl < q_thr) begin
          pq_d = ~quiet_q;  quiet_d = 1'b1;
        end else begin
          pq_d = 1'b0;  quiet_d = 1'b0;
        end
        ptr_d = pos;
        acc_d = per_acc;
        tot_d = '0;
        if (!cand) state_d = StDone;
        else if (per_acc > lbd_pkg::AccW'(D)) state_d = StMul;
        else state_d = StRd;
      end
      StRd: begin
        rdv_d   = hv_q[ptr_q];
        state_d = StAcc;
      end
      StAcc: begin
        tot_d = tot_q + ent_ext;
        ptr_d = lbd_pkg::IdxW'(ptr_nx);
        acc_d = acc_nx;
        state_d = (acc_nx > lbd_pkg::AccW'(D)) ? StMul : StRd;
      end
      StMul: begin
        neg_d  = prod < 0;
        dq_d   = (prod < 0) ? lbd_pkg::ProdW'(-prod) : lbd_pkg::ProdW'(prod);
        dcnt_d = '0;
        state_d = StDiv;
      end
      StDiv: begin
        if (dcnt_q == '0) begin
          // while dcnt_q is zero: quotient magnitude; afterwards: compare
          dq_d   = lbd_pkg::ProdW'(dv_p[lbd_pkg::RecipSh +: lbd_pkg::LvlW]);
          dcnt_d = dcnt_q + 1'b1;
        end else begin
          if (score > signed'((lbd_pkg::ProdW+lbd_pkg::SensW+2)'(lvl_q))) begin
            pb_d   = 1'b1;
            prev_d = fsb_q;
            rb_d   = (lbd_pkg::SumW'(rb_q) + lbd_pkg::SumW'(fsb_q) >= lbd_pkg::SumW'(D)) ?
                     lbd_pkg::IdxW'(lbd_pkg::SumW'(rb_q) + lbd_pkg::SumW'(fsb_q) -
                                    lbd_pkg::SumW'(D)) :
                     lbd_pkg::IdxW'(lbd_pkg::SumW'(rb_q) + lbd_pkg::SumW'(fsb_q));
            fsb_d  = '0;
          end
          state_d = StDone;
        end
      end
      StDone: begin
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1;  ob_d = pb_q;  ot_d = pt_q;  oq_d = pq_q;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      lvl_q <= '0;  fsb_q <= '0;  prev_q <= '0;  rb_q <= '0;
      quiet_q <= 1'b0;  hv_q <= '0;  ov_q <= 1'b0;
      silence_q   <= lbd_pkg::LvlW'(2000);
      thick_flr_q <= lbd_pkg::LvlW'(1500);
      q_enter_q   <= lbd_pkg::LvlW'(500);
      q_exit_q    <= lbd_pkg::LvlW'(1500);
      min_gap_q   <= lbd_pkg::GapW'(15);
      base_sens_q <= lbd_pkg::SensW'(4);
    end else begin
      state_q <= state_d;
      lvl_q <= lvl_d;  fsb_q <= fsb_d;  prev_q <= prev_d;  rb_q <= rb_d;
      quiet_q <= quiet_d;  hv_q <= hv_d;  ov_q <= ov_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          lbd_pkg::RegSilence:  silence_q   <= cfg_data_i;
          lbd_pkg::RegThickFlr: thick_flr_q <= cfg_data_i;
          lbd_pkg::RegQuietEnt: q_enter_q   <= cfg_data_i;
          lbd_pkg::RegQuietExt: q_exit_q    <= cfg_data_i;
          lbd_pkg::RegMinGap:   min_gap_q   <= cfg_data_i[lbd_pkg::GapW-1:0];
          lbd_pkg::RegBaseSens: base_sens_q <= cfg_data_i[lbd_pkg::SensW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) loud_q <= loudness_i;
    ptr_q <= ptr_d;  acc_q <= acc_d;  tot_q <= tot_d;  rdv_q <= rdv_d;
    dq_q <= dq_d;  neg_q <= neg_d;  dcnt_q <= dcnt_d;
    pb_q <= pb_d;  pt_q <= pt_d;  pq_q <= pq_d;
    ob_q <= ob_d;  ot_q <= ot_d;  oq_q <= oq_d;
  end

  assign in_stall_o    = (state_q != StIdle);
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = ov_q;
  assign beat_o        = ob_q;
  assign thickness_o   = ot_q;
  assign quiet_start_o = oq_q;

  a_rb_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rb_q < lbd_pkg::IdxW'(D)) else $error("ring base out of range");
  a_fsb_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lbd_pkg::SumW'(fsb_q) <= lbd_pkg::SumW'(D)) else $error("frame count out of range");
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRd) |-> (ptr_q < lbd_pkg::IdxW'(D))) else $error("read pointer out of range");
  a_rd_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRd) |=> (state_q == StAcc)) else $error("read not followed by accumulate");
  a_beat_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv && pb_d && !pb_q) |=> (fsb_q == '0)) else $error("beat left count");

endmodule
